>>> sv/crt_reconstruct_macros.svh
// assertion macros for the crt reconstruction checker
// no dependencies
`ifndef CRT_RECONSTRUCT_MACROS_SVH
`define CRT_RECONSTRUCT_MACROS_SVH
`define CRT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> sv/crt_pkg.sv
// package for the crt reconstruction block: widths, payload structs, states
// no dependencies
package crt_pkg;
  localparam int unsigned WordW = 31;
  localparam int unsigned CntW = 6;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = 1;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t residue;
    word_t factor_modulus;
    logic  last_factor;
  } crt_in_t;

  typedef struct packed {
    word_t solution;
    logic  bad_modulus;
  } crt_out_t;

  typedef struct packed {
    word_t residue;
    word_t factor_modulus;
    logic  last_factor;
    logic  zero_factor;
  } crt_job_t;

  typedef enum logic [3:0] {
    StIdle, StReduce, StRedDiv, StSetup, StDivQ, StEuDiv,
    StEuMul, StEuNext, StMulA, StMulB, StFin
  } crt_state_e;
endpackage

>>> sv/crt_front.sv
// front end: accepts requests, flags zero factors and queues them
// depends on crt_pkg
module crt_front import crt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  crt_in_t  in_data_i,
  output logic     job_valid_o,
  input  logic     job_take_i,
  output crt_job_t job_o
);
  crt_job_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push, do_pop;

  assign full        = (cnt_q == (QPtrW+1)'(QDepth));
  assign do_push     = push && !full;
  assign job_valid_o = (cnt_q != '0);
  assign do_pop      = job_take_i && job_valid_o;
  assign job_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= '{residue: in_data_i.residue,
                       factor_modulus: in_data_i.factor_modulus,
                       last_factor: in_data_i.last_factor,
                       zero_factor: (in_data_i.factor_modulus == '0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
    end
  end
endmodule

>>> sv/crt_back.sv
// back end: bit-serial division, extended euclid and modular multiply
// depends on crt_pkg
module crt_back import crt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  word_t    prime_i,
  input  logic     job_valid_i,
  output logic     job_take_o,
  input  crt_job_t job_i,
  output logic     out_valid_o,
  input  logic     out_take_i,
  output crt_out_t out_o
);
  crt_state_e state_q, state_d;
  word_t      bigm_q, sum_q, m_q, r_q, q_q;
  logic       err_q, last_q;
  // divider
  word_t      dn_q, dd_q, quo_q, rem_q;
  logic [CntW-1:0] cnt_q;
  // euclid
  word_t      tp_q, tc_q;
  // multiplier
  word_t      ma_q, mb_q, mr_q, mn_q;
  crt_out_t   out_q;
  logic       outv_q;

  logic [WordW:0] rem_sh, ma_dbl, mr_add;
  logic           div_sub, div_last, out_load;
  word_t          rem_nx, quo_nx, ma_dbl_r, mr_add_r, sum_add, tnext;
  word_t          bigm;

  assign bigm = (prime_i >= word_t'(2)) ? prime_i - word_t'(1) : '0;
  assign rem_sh = {rem_q, dn_q[WordW-1]};
  assign div_sub = (rem_sh >= {1'b0, dd_q});
  assign rem_nx = div_sub ? word_t'(rem_sh - {1'b0, dd_q}) : word_t'(rem_sh);
  assign quo_nx = {quo_q[WordW-2:0], div_sub};
  assign div_last = (cnt_q == CntW'(1));
  assign ma_dbl = {1'b0, ma_q} + {1'b0, ma_q};
  assign ma_dbl_r = (ma_dbl >= {1'b0, mn_q}) ? word_t'(ma_dbl - {1'b0, mn_q})
                                              : word_t'(ma_dbl);
  assign mr_add = {1'b0, mr_q} + {1'b0, ma_q};
  assign mr_add_r = (mr_add >= {1'b0, mn_q}) ? word_t'(mr_add - {1'b0, mn_q})
                                              : word_t'(mr_add);
  assign tnext = (tp_q >= mr_q) ? tp_q - mr_q : tp_q + (m_q - mr_q);
  assign sum_add = (sum_q >= bigm_q - mr_q) ? sum_q - (bigm_q - mr_q) : sum_q + mr_q;

  assign out_valid_o = outv_q;
  assign out_o       = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (job_valid_i) state_d = StReduce;
      end
      StReduce: begin
        if (bigm_q != '0 && sum_q >= bigm_q) state_d = StRedDiv;
        else state_d = StSetup;
      end
      StRedDiv: begin
        if (div_last) state_d = StSetup;
      end
      StSetup: begin
        if (m_q == '0 || bigm_q == '0) state_d = StFin;
        else state_d = StDivQ;
      end
      StDivQ: begin
        if (div_last) begin
          if (quo_nx == '0) state_d = StFin;
          else state_d = StEuDiv;
        end
      end
      StEuDiv: begin
        if (div_last) state_d = StEuMul;
      end
      StEuMul: begin
        if (mb_q == '0) state_d = StEuNext;
      end
      StEuNext: begin
        if (rem_q != '0) state_d = StEuDiv;
        else state_d = StMulA;
      end
      StMulA: begin
        if (mb_q == '0) state_d = StMulB;
      end
      StMulB: begin
        if (mb_q == '0) state_d = StFin;
      end
      StFin: begin
        if (!last_q || out_load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    job_take_o = (state_q == StIdle) && job_valid_i;
    out_load   = (state_q == StFin) && last_q && (!outv_q || out_take_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      bigm_q  <= '0;
      sum_q   <= '0;
      m_q     <= '0;
      r_q     <= '0;
      q_q     <= '0;
      err_q   <= 1'b0;
      last_q  <= 1'b0;
      dn_q    <= '0;
      dd_q    <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      tp_q    <= '0;
      tc_q    <= '0;
      ma_q    <= '0;
      mb_q    <= '0;
      mr_q    <= '0;
      mn_q    <= '0;
      out_q   <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) outv_q <= 1'b1;
      else if (out_take_i) outv_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            r_q    <= job_i.residue;
            m_q    <= job_i.factor_modulus;
            last_q <= job_i.last_factor;
            bigm_q <= bigm;
            if (job_i.zero_factor) err_q <= 1'b1;
            if (bigm == '0) sum_q <= '0;
          end
        end
        StReduce: begin
          // stored sum from an earlier modulus
          if (bigm_q != '0 && sum_q >= bigm_q) begin
            dn_q  <= sum_q;
            dd_q  <= bigm_q;
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= CntW'(WordW);
          end
        end
        StSetup: begin
          if (!(m_q == '0 || bigm_q == '0)) begin
            dn_q  <= bigm_q;
            dd_q  <= m_q;
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= CntW'(WordW);
          end
        end
        StRedDiv, StDivQ, StEuDiv: begin
          if (div_last && state_q == StDivQ) begin
            // q = M / m, then euclid on (m, q)
            q_q   <= quo_nx;
            tp_q  <= '0;
            tc_q  <= (m_q == word_t'(1)) ? '0 : word_t'(1);
            dn_q  <= m_q;
            dd_q  <= quo_nx;
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= CntW'(WordW);
          end else begin
            dn_q  <= dn_q << 1;
            rem_q <= rem_nx;
            quo_q <= quo_nx;
            cnt_q <= cnt_q - CntW'(1);
          end
          if (div_last && state_q == StRedDiv) sum_q <= rem_nx;
          if (div_last && state_q == StEuDiv) begin
            ma_q <= tc_q;
            mb_q <= quo_nx;
            mr_q <= '0;
            mn_q <= m_q;
          end
        end
        StEuMul, StMulA, StMulB: begin
          if (mb_q != '0) begin
            if (mb_q[0]) mr_q <= mr_add_r;
            ma_q <= ma_dbl_r;
            mb_q <= mb_q >> 1;
          end else if (state_q == StMulA) begin
            ma_q <= mr_q;
            mb_q <= q_q;
            mr_q <= '0;
          end else if (state_q == StMulB) begin
            sum_q <= sum_add;
          end
        end
        StEuNext: begin
          tp_q <= tc_q;
          tc_q <= tnext;
          if (rem_q != '0) begin
            dn_q  <= dd_q;
            dd_q  <= rem_q;
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= CntW'(WordW);
          end else begin
            ma_q <= tc_q;
            mb_q <= r_q;
            mr_q <= '0;
            mn_q <= bigm_q;
          end
        end
        StFin: begin
          if (out_load) begin
            out_q <= '{solution: sum_q, bad_modulus: err_q};
            sum_q <= '0;
            err_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

>>> sv/crt_reconstruct.sv
// crt reconstruction block
// channels: queue-style request input (push/full), result output (empty/pop)
// and a prime write port (cfg_we_i/cfg_data_i) with no wait and no read-back.
// one request = residue, factor modulus and a last flag; a result is given
// only for a request with the last flag set: the sum of residue * inverse *
// quotient over the set, modulo the configured prime minus one, plus an
// error flag if any factor was zero.
// a front queue of two entries takes requests while the back end works on one.
// per request the back end steps through its control states, a reduction
// division when the stored sum must be reduced to a new modulus, the
// bit-serial quotient division, extended euclid rounds of one division and
// one multiply each and the two final modular multiplies; a zero factor goes
// from setup straight to the final state; requests are handled one at a time.
// one result waits in an output register; a stalled receiver stops the back
// end only when the next result is due, then the front queue fills and full rises.
// reset clears the running sum, the error flag and the queue and sets the prime to 3;
// the user must write the prime only while no request is in flight; not enforced.
module crt_reconstruct import crt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  crt_in_t  in_data_i,
  output logic     empty,
  input  logic     pop,
  output crt_out_t out_data_o,
  input  logic     cfg_we_i,
  input  word_t    cfg_data_i
);
  word_t    prime_q;
  logic     job_valid, job_take, out_valid;
  crt_job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prime_q <= word_t'(3);
    else if (cfg_we_i) prime_q <= cfg_data_i;
  end

  crt_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_data_i,
    .job_valid_o(job_valid), .job_take_i(job_take), .job_o(job)
  );

  crt_back u_back (
    .clk_i, .rst_ni, .prime_i(prime_q),
    .job_valid_i(job_valid), .job_take_o(job_take), .job_i(job),
    .out_valid_o(out_valid), .out_take_i(pop), .out_o(out_data_o)
  );

  assign empty = !out_valid;
endmodule

>>> sv/crt_checker.sv
// port-level checker for crt_reconstruct, bound to the top level
// depends on crt_pkg and crt_reconstruct_macros.svh
`include "crt_reconstruct_macros.svh"
module crt_assert import crt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input crt_out_t out_data_o
);
  `CRT_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_data_o))
  `CRT_ASSERT_IMPL(a_flags_known, clk_i, rst_ni, 1'b1, (!$isunknown({full, empty})))
  `CRT_ASSERT_IMPL(a_data_known, clk_i, rst_ni, !empty, (!$isunknown(out_data_o)))
endmodule

bind crt_reconstruct crt_assert u_checker (
  .clk_i, .rst_ni, .full, .empty, .pop, .out_data_o
);
